@@ hdl/cbh_pkg.sv @@
// ----------------------------------------------------------------------------
// Caseless string bucket hash package
// Shared widths, constants, types and the case-folding function.
// ----------------------------------------------------------------------------
package cbh_pkg;

    localparam int CHAR_W   = 8;
    localparam int HASH_W   = 64;
    localparam int BUCKET_W = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int STEP_W   = $clog2(HASH_W);

    localparam logic [HASH_W-1:0]   HASH_SEED    = HASH_W'(5381);
    localparam int                  HASH_SHIFT   = 5;
    localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(1);

    localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // Register index, taken from the word address.
    typedef enum logic {
        REG_BUCKET_COUNT = 1'b0
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // C-locale lower-case fold: only 'A' to 'Z' move.
    function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        r = b;
        if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ hdl/cbh_if.sv @@
// ----------------------------------------------------------------------------
// Caseless string bucket hash channels
// Valid/ready channels for character items and hash results.
// ----------------------------------------------------------------------------
interface cbh_in_if;
    import cbh_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              end_of_string;

    modport source (output valid, output char_byte, output end_of_string, input ready);
    modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface cbh_out_if;
    import cbh_pkg::*;

    logic                valid;
    logic                ready;
    logic [BUCKET_W-1:0] bucket_index;
    logic [HASH_W-1:0]   full_hash;

    modport source (output valid, output bucket_index, output full_hash, input ready);
    modport sink   (input valid, input bucket_index, input full_hash, output ready);
endinterface

@@ hdl/caseless_string_bucket_hash.sv @@
// ----------------------------------------------------------------------------
// Caseless string bucket hash
// Folds case-insensitive string bytes into a 64-bit multiply-by-33 hash and
// reduces the final hash modulo a configured bucket count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                          Transfer when
//  i_req     in         char_byte, end_of_string         valid && ready
//  o_rsp     out        bucket_index, full_hash          valid && ready
//  APB       in/out     bucket_count at address 0        psel && penable && pwrite
//
//  A character item updates the hash with a single shift-add.
//  An end item starts a restoring subtract unit that produces the remainder
//  one dividend bit per cycle; then the result is handed to the output
//  register, later while that register still holds an unaccepted result.
//  i_req is not ready while the remainder is being computed or waits.
//  Reset is synchronous and active low; it sets the hash seed and a bucket
//  count of one. A result stalled at the output holds its value.
// ----------------------------------------------------------------------------
module caseless_string_bucket_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cbh_in_if.sink                     i_req,
    cbh_out_if.source                  o_rsp,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [cbh_pkg::APB_AW-1:0] i_paddr,
    input  logic [cbh_pkg::APB_DW-1:0] i_pwdata,
    output logic [cbh_pkg::APB_DW-1:0] o_prdata,
    output logic                       o_pready
);
    import cbh_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [HASH_W-1:0]   r_hash;
    logic [HASH_W-1:0]   r_dvd;
    logic [HASH_W-1:0]   r_full;
    logic [BUCKET_W-1:0] r_rem;
    logic [STEP_W-1:0]   r_cnt;
    logic [BUCKET_W-1:0] r_bucket;
    logic                r_out_valid;
    logic [BUCKET_W-1:0] r_out_index;
    logic [HASH_W-1:0]   r_out_hash;

    logic                in_xfer;
    logic                out_free;
    logic                load_out;
    logic                cfg_wr;
    t_reg_idx            reg_idx;
    logic [HASH_W-1:0]   hash_next;
    logic [BUCKET_W:0]   rem_sh;
    logic [BUCKET_W:0]   rem_sub;
    logic                rem_ge;

    assign reg_idx  = t_reg_idx'(i_paddr[2]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_prdata = (reg_idx == REG_BUCKET_COUNT) ? r_bucket : '0;

    assign in_xfer  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // hash * 33 + folded byte, wrapping at 64 bits.
    assign hash_next = (r_hash << HASH_SHIFT) + r_hash
                     + HASH_W'(fold_lower(i_req.char_byte));

    // One restoring step of the remainder: shift in the next dividend bit.
    assign rem_sh  = {r_rem, r_dvd[HASH_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_bucket};
    assign rem_sub = rem_sh - {1'b0, r_bucket};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && i_req.end_of_string) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == STEP_W'(HASH_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= HASH_SEED;
            r_bucket <= BUCKET_RESET;
        end else begin
            if (cfg_wr && reg_idx == REG_BUCKET_COUNT) begin
                r_bucket <= i_pwdata[BUCKET_W-1:0];
            end
            if (in_xfer) begin
                r_hash <= i_req.end_of_string ? HASH_SEED : hash_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_req.end_of_string) begin
            r_dvd  <= r_hash;
            r_full <= r_hash;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_state == ST_DIV) begin
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
            r_rem <= rem_ge ? rem_sub[BUCKET_W-1:0] : rem_sh[BUCKET_W-1:0];
            r_cnt <= r_cnt + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            // A bucket count of zero has no meaningful remainder; report zero.
            r_out_index <= (r_bucket == '0) ? '0 : r_rem;
            r_out_hash  <= r_full;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.bucket_index = r_out_index;
    assign o_rsp.full_hash    = r_out_hash;

endmodule

@@ hdl/cbh_checker.sv @@
// ----------------------------------------------------------------------------
// Caseless string bucket hash checker
// Port-level assertions on the channel handshakes of the hash block.
// ----------------------------------------------------------------------------
module cbh_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_end,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [cbh_pkg::BUCKET_W-1:0] i_out_index,
    input logic [cbh_pkg::HASH_W-1:0]   i_out_hash
);
    import cbh_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_index) && $stable(i_out_hash))
        else $error("result payload changed while stalled");

    // An end transfer starts the remainder unit, so input stalls next cycle.
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_end |=> !i_in_ready)
        else $error("input ready right after an end transfer");

    // Character transfers never stall the input.
    a_char_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_end |=> i_in_ready)
        else $error("input stalled after a character transfer");

    // A new result appears only at the end of a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a pending end item");

endmodule

bind caseless_string_bucket_hash cbh_checker u_cbh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_end    (i_req.end_of_string),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_index (o_rsp.bucket_index),
    .i_out_hash  (o_rsp.full_hash)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Caseless string bucket hash testbench
// Feeds strings one byte per transfer, with idle and stall bursts, across
// several bucket counts. The expected full hash and bucket index are predicted
// in step with each accepted byte and checked against every result transfer.
// ----------------------------------------------------------------------------
module testbench;
    import cbh_pkg::*;

    localparam logic [HASH_W-1:0]   DJB_START   = 64'd5381;
    localparam int                  DJB_SHIFT   = 5;
    localparam logic [APB_AW-1:0]   BUCKET_ADDR = APB_AW'(4 * int'(REG_BUCKET_COUNT));
    localparam int                  PHASE_ITEMS = 57;
    localparam int                  NUM_PHASES  = 7;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eos;
    } str_item_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [HASH_W-1:0]   hash;
    } hash_result_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_psel;
    logic              i_penable;
    logic              i_pwrite;
    logic [APB_AW-1:0] i_paddr;
    logic [APB_DW-1:0] i_pwdata;
    logic [APB_DW-1:0] o_prdata;
    logic              o_pready;

    cbh_in_if  req_if ();
    cbh_out_if rsp_if ();

    caseless_string_bucket_hash dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_rsp     (rsp_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    str_item_t    string_bytes[$];
    hash_result_t expected_hashes[$];

    logic [HASH_W-1:0]   running_hash;
    logic [BUCKET_W-1:0] bucket_count;
    logic                req_taken;
    int n_queued;
    int n_taken;
    int n_errors;
    int n_strings;
    int n_chars;
    int n_settings;
    int gap_pct;
    int stall_pct;
    int gap_left;
    int stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_hashes.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] lower_byte(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                   input logic [HASH_W-1:0] want);
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Prediction and checking share one block so that a result transfer and a
    // request transfer at the same edge are handled in a fixed order.
    always @(posedge i_clk) begin
        hash_result_t want;
        if (!i_rst_n) begin
            running_hash = DJB_START;
            bucket_count = BUCKET_W'(1);
            req_taken    = 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("unexpected result, full_hash", rsp_if.full_hash, '0);
                end else begin
                    want = expected_hashes.pop_front();
                    n_strings++;
                    if (rsp_if.full_hash !== want.hash) begin
                        report_mismatch("full_hash", rsp_if.full_hash, want.hash);
                    end
                    if (rsp_if.bucket_index !== want.bucket) begin
                        report_mismatch("bucket_index", HASH_W'(rsp_if.bucket_index),
                                        HASH_W'(want.bucket));
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && o_pready && i_paddr == BUCKET_ADDR) begin
                bucket_count = i_pwdata[BUCKET_W-1:0];
            end
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                n_taken++;
                if (req_if.end_of_string) begin
                    // A bucket count of zero yields index zero.
                    want.bucket = (bucket_count == '0) ? '0 :
                                  BUCKET_W'(running_hash % {32'd0, bucket_count});
                    want.hash   = running_hash;
                    expected_hashes.push_back(want);
                    running_hash = DJB_START;
                end else begin
                    running_hash = (running_hash << DJB_SHIFT) + running_hash +
                                   HASH_W'(lower_byte(req_if.char_byte));
                    n_chars++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_taken) begin
            // Hold the byte until the transfer completes.
        end else if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
        end else if (string_bytes.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            gap_left = $urandom_range(0, 11);
        end else if (string_bytes.size() != 0) begin
            str_item_t it;
            it = string_bytes.pop_front();
            req_if.valid         <= 1'b1;
            req_if.char_byte     <= it.ch;
            req_if.end_of_string <= it.eos;
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 11);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [CHAR_W-1:0] ch, input logic eos);
        str_item_t it;
        it.ch  = ch;
        it.eos = eos;
        string_bytes.push_back(it);
        n_queued++;
    endtask

    // Mostly letters of either case, so the fold is exercised, plus raw bytes.
    task automatic queue_random_string(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_byte(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
                4, 5, 6:    push_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
                default:    push_byte(8'($urandom), 1'b0);
            endcase
        end
        push_byte(8'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        while (n_taken != n_queued || expected_hashes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_bucket_count(input logic [BUCKET_W-1:0] value);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= BUCKET_ADDR;
        i_pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        n_settings++;
    endtask

    initial begin
        logic [BUCKET_W-1:0] settings[NUM_PHASES];
        int phase;
        int start;
        int len;
        req_if.valid         = 1'b0;
        req_if.char_byte     = '0;
        req_if.end_of_string = 1'b0;
        rsp_if.ready         = 1'b0;
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
        i_paddr   = '0;
        i_pwdata  = '0;
        i_rst_n   = 1'b0;
        n_queued = 0; n_taken = 0; n_errors = 0;
        n_strings = 0; n_chars = 0; n_settings = 1;
        gap_pct = 20; stall_pct = 20; gap_left = 0; stall_left = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset bucket count: empty strings, letter boundaries, byte extremes.
        push_byte(8'h00, 1'b1);
        push_byte(8'h41, 1'b0); push_byte(8'h5A, 1'b0);
        push_byte(8'h61, 1'b0); push_byte(8'h7A, 1'b0);
        push_byte(8'h40, 1'b0); push_byte(8'h5B, 1'b0);
        push_byte(8'h60, 1'b0); push_byte(8'h7B, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h7F, 1'b0);
        push_byte(8'h55, 1'b0); push_byte(8'hAA, 1'b0);
        push_byte(8'h41, 1'b1);
        push_byte(8'h5A, 1'b1);
        wait_drained();

        settings[0] = '0;
        settings[1] = 32'hFFFF_FFFF;
        settings[2] = 32'h8000_0000;
        settings[3] = 32'd7;
        settings[4] = 32'($urandom);
        settings[5] = 32'($urandom_range(2, 1000));
        settings[6] = 32'd1;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // The last phase runs with both sides at full rate.
            case (phase % 3)
                0:       begin gap_pct = 25; stall_pct = 10; end
                1:       begin gap_pct = 0;  stall_pct = 0;  end
                default: begin gap_pct = 10; stall_pct = 40; end
            endcase
            if (phase == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            repeat (8) @(negedge i_clk);
            write_bucket_count(settings[phase]);
            start = n_queued;
            while (n_queued - start < PHASE_ITEMS) begin
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                queue_random_string(len);
            end
            wait_drained();
        end

        // Let any stray result show up before closing.
        repeat (80) @(negedge i_clk);
        $display("Checked %0d strings built from %0d characters", n_strings, n_chars);
        $display("Bucket count took %0d settings, from zero to all ones", n_settings);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ caseless_string_bucket_hash.f @@
hdl/cbh_pkg.sv
hdl/cbh_if.sv
hdl/caseless_string_bucket_hash.sv
hdl/cbh_checker.sv
dv/testbench.sv
